// ===== sv/bcpu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcpu_pkg
// Shared types and constants of the bit cursor pack/unpack block.
// ----------------------------------------------------------------------------
package bcpu_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = 7;
    localparam int POS_W  = 16;
    localparam int OFS_W  = 17;
    localparam int ACT_W  = 3;
    localparam int CUR_W  = 17;
    localparam int WIN_W  = 72;
    localparam int NB_W   = 4;
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;

    localparam logic [CNT_W-1:0]  MAX_ACCESS_BITS   = 7'd64;
    localparam logic [7:0]        BYTE_MASK         = 8'hFF;
    localparam logic [2:0]        BIT_IN_BYTE       = 3'h7;
    localparam logic [APB_AW-1:0] REG_BUFFER_BITS   = 2'd0;
    localparam logic [15:0]       BUFFER_BITS_RESET = 16'd32768;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ     = 3'd0,
        ACT_WRITE    = 3'd1,
        ACT_SEEK_ABS = 3'd2,
        ACT_SEEK_REL = 3'd3,
        ACT_ZERO_PAD = 3'd4,
        ACT_CLEAR    = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RUN,
        ST_CLEAR,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/bcpu_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcpu_req_if / bcpu_rsp_if
// Valid/ready channels for requests and results of the bit cursor block.
// ----------------------------------------------------------------------------
interface bcpu_req_if;
    logic                                valid;
    logic                                ready;
    logic [bcpu_pkg::ACT_W-1:0]          action;
    logic [bcpu_pkg::CNT_W-1:0]          bit_count;
    logic [bcpu_pkg::DATA_W-1:0]         write_data;
    logic signed [bcpu_pkg::OFS_W-1:0]   seek_offset;

    modport source (output valid, action, bit_count, write_data, seek_offset,
                    input ready);
    modport sink (input valid, action, bit_count, write_data, seek_offset,
                  output ready);
endinterface

interface bcpu_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bcpu_pkg::DATA_W-1:0]   read_data;
    logic [bcpu_pkg::CNT_W-1:0]    done_count;
    logic [bcpu_pkg::POS_W-1:0]    previous_position;

    modport source (output valid, read_data, done_count, previous_position,
                    input ready);
    modport sink (input valid, read_data, done_count, previous_position,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/bcpu_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcpu_apb_regs
// APB register file holding the buffer size in bits.
// ----------------------------------------------------------------------------
module bcpu_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcpu_pkg::APB_AW-1:0]   paddr,
    input  logic [bcpu_pkg::APB_DW-1:0]   pwdata,
    output logic [bcpu_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [15:0]                   o_buffer_bits
);

    logic [15:0] r_buffer_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_bits <= bcpu_pkg::BUFFER_BITS_RESET;
        end else if (psel && penable && pwrite && paddr == bcpu_pkg::REG_BUFFER_BITS) begin
            r_buffer_bits <= pwdata[15:0];
        end
    end

    always_comb begin
        unique case (paddr)
            bcpu_pkg::REG_BUFFER_BITS: prdata = {16'd0, r_buffer_bits};
            default:                   prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign o_buffer_bits = r_buffer_bits;

endmodule

`default_nettype wire

// ===== sv/bcpu_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcpu_store
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bcpu_store #(
    parameter int STORE_BYTES = 4096,
    parameter int AW          = 12
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/bcpu_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcpu_engine
// Cursor, clipping and the byte-at-a-time read-modify-write sequencer.
// ----------------------------------------------------------------------------
module bcpu_engine #(
    parameter int STORE_BYTES = 4096,
    parameter int AW          = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_buffer_bits,
    bcpu_req_if.sink      i_req,
    bcpu_rsp_if.source    o_rsp,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data
);

    localparam int          SW         = AW + 1;
    localparam logic [31:0] STORE_BITS = 32'(STORE_BYTES) * 32'd8;

    localparam int CW = bcpu_pkg::CUR_W;
    localparam int WW = bcpu_pkg::WIN_W;

    bcpu_pkg::t_state r_state, n_state;

    logic [CW-1:0]               r_cursor;
    logic [2:0]                  r_act;
    logic [2:0]                  r_off;
    logic [bcpu_pkg::CNT_W-1:0]  r_cnt;
    logic [bcpu_pkg::NB_W-1:0]   r_nb;
    logic [bcpu_pkg::NB_W-1:0]   r_k_iss;
    logic [bcpu_pkg::NB_W-1:0]   r_pend_k;
    logic                        r_pend;
    logic [AW-1:0]               r_base;
    logic [WW-1:0]               r_wwin;
    logic [WW-1:0]               r_mwin;
    logic [WW-1:0]               r_rwin;
    logic [bcpu_pkg::POS_W-1:0]  r_prev;
    logic [SW-1:0]               r_sweep;
    logic [SW-1:0]               r_sweep_end;

    logic                        r_out_valid;
    logic [bcpu_pkg::DATA_W-1:0] r_out_rdata;
    logic [bcpu_pkg::CNT_W-1:0]  r_out_cnt;
    logic [bcpu_pkg::POS_W-1:0]  r_out_prev;

    // request decode and clipping
    logic                       acc;
    logic [15:0]                size16;
    logic [CW-1:0]              size17;
    logic [CW-1:0]              wlim;
    logic [CW-1:0]              limit;
    logic [CW-1:0]              room;
    logic [bcpu_pkg::CNT_W-1:0] want;
    logic [bcpu_pkg::CNT_W-1:0] capped;
    logic [bcpu_pkg::CNT_W-1:0] done;
    logic [2:0]                 off;
    logic [7:0]                 nb_sum;
    logic [bcpu_pkg::NB_W-1:0]  nb;
    logic [WW-1:0]              mask;
    logic [bcpu_pkg::DATA_W-1:0] wdata;
    logic signed [18:0]         ofs19;
    logic signed [18:0]         tgt;
    logic [CW-1:0]              seek_pos;
    logic [17:0]                clr_bytes;
    logic                       uses_store;

    // sequencer datapath
    logic                       sweeping;
    logic                       load_out;
    logic [6:0]                 pend_bit;
    logic [7:0]                 mbyte;
    logic [7:0]                 wbyte;
    logic [WW-1:0]              rd_shift;

    assign acc = i_req.valid && (r_state == bcpu_pkg::ST_IDLE);

    always_comb begin
        size16 = ({16'd0, i_buffer_bits} > STORE_BITS) ? STORE_BITS[15:0] : i_buffer_bits;
        size17 = {1'b0, size16};
        wlim   = (size17 + 17'd7) & 17'h1FFF8;
        off    = r_cursor[2:0];
        capped = (i_req.bit_count > bcpu_pkg::MAX_ACCESS_BITS) ?
                 bcpu_pkg::MAX_ACCESS_BITS : i_req.bit_count;
        want       = '0;
        limit      = wlim;
        wdata      = '0;
        uses_store = 1'b0;
        unique case (i_req.action)
            bcpu_pkg::ACT_READ: begin
                want       = capped;
                limit      = size17;
                uses_store = 1'b1;
            end
            bcpu_pkg::ACT_WRITE: begin
                want       = capped;
                wdata      = i_req.write_data;
                uses_store = 1'b1;
            end
            bcpu_pkg::ACT_ZERO_PAD: begin
                if (off != 3'd0) begin
                    want = {3'd0, 4'd8 - {1'b0, off}};
                end
                uses_store = 1'b1;
            end
            default: begin
                want = '0;
            end
        endcase
        room   = (r_cursor < limit) ? limit - r_cursor : '0;
        done   = ({10'd0, want} > room) ? room[bcpu_pkg::CNT_W-1:0] : want;
        nb_sum = {5'd0, off} + {1'b0, done} + 8'd7;
        nb     = nb_sum[6:3];
        mask   = (WW'(1) << done) - WW'(1);

        ofs19 = {{2{i_req.seek_offset[bcpu_pkg::OFS_W-1]}}, i_req.seek_offset};
        if (i_req.action == bcpu_pkg::ACT_SEEK_REL) begin
            tgt = $signed({2'b00, r_cursor}) + ofs19;
        end else begin
            tgt = ofs19;
        end
        // saturate to 0..size
        if (tgt < 0) begin
            seek_pos = '0;
        end else if (tgt > $signed({2'b00, size17})) begin
            seek_pos = size17;
        end else begin
            seek_pos = tgt[CW-1:0];
        end
        clr_bytes = {1'b0, size17} + 18'd7;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bcpu_pkg::ST_INIT: begin
                if (r_sweep == r_sweep_end) n_state = bcpu_pkg::ST_IDLE;
            end
            bcpu_pkg::ST_IDLE: begin
                if (acc) begin
                    if (uses_store && done != '0) begin
                        n_state = bcpu_pkg::ST_RUN;
                    end else if (i_req.action == bcpu_pkg::ACT_CLEAR) begin
                        n_state = bcpu_pkg::ST_CLEAR;
                    end else begin
                        n_state = bcpu_pkg::ST_DONE;
                    end
                end
            end
            bcpu_pkg::ST_RUN: begin
                if (r_k_iss == r_nb && !r_pend) n_state = bcpu_pkg::ST_DONE;
            end
            bcpu_pkg::ST_CLEAR: begin
                if (r_sweep == r_sweep_end) n_state = bcpu_pkg::ST_DONE;
            end
            bcpu_pkg::ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) n_state = bcpu_pkg::ST_IDLE;
            end
            default: n_state = bcpu_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_req.ready = (r_state == bcpu_pkg::ST_IDLE);
        sweeping    = (r_state == bcpu_pkg::ST_INIT || r_state == bcpu_pkg::ST_CLEAR) &&
                      (r_sweep != r_sweep_end);
        load_out    = (r_state == bcpu_pkg::ST_DONE) && (!r_out_valid || o_rsp.ready);
        pend_bit    = {r_pend_k[3:0], 3'b000};
        mbyte       = r_mwin[pend_bit +: 8];
        wbyte       = r_wwin[pend_bit +: 8];

        o_rd_en   = (r_state == bcpu_pkg::ST_RUN) && (r_k_iss != r_nb);
        o_rd_addr = r_base + AW'(r_k_iss);

        if (sweeping) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_sweep[AW-1:0];
            o_wr_data = '0;
        end else begin
            o_wr_en   = (r_state == bcpu_pkg::ST_RUN) && r_pend &&
                        (r_act != bcpu_pkg::ACT_READ);
            o_wr_addr = r_base + AW'(r_pend_k);
            o_wr_data = ((i_rd_data & ~mbyte) | (wbyte & mbyte)) & bcpu_pkg::BYTE_MASK;
        end

        rd_shift = (r_rwin & r_mwin) >> r_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bcpu_pkg::ST_INIT;
            r_cursor    <= '0;
            r_sweep     <= '0;
            r_sweep_end <= SW'(STORE_BYTES);
            r_pend      <= 1'b0;
            r_k_iss     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (sweeping) begin
                r_sweep <= r_sweep + SW'(1);
            end

            if (acc) begin
                r_act    <= i_req.action;
                r_off    <= off;
                r_cnt    <= done;
                r_nb     <= nb;
                r_base   <= AW'(r_cursor[CW-1:3]);
                r_wwin   <= (WW'(wdata) & mask) << off;
                r_mwin   <= mask << off;
                r_rwin   <= '0;
                r_prev   <= r_cursor[bcpu_pkg::POS_W-1:0];
                r_k_iss  <= '0;
                r_pend   <= 1'b0;
                if (i_req.action == bcpu_pkg::ACT_SEEK_ABS ||
                    i_req.action == bcpu_pkg::ACT_SEEK_REL) begin
                    r_cursor <= seek_pos;
                end else begin
                    r_cursor <= r_cursor + CW'(done);
                end
                if (i_req.action == bcpu_pkg::ACT_CLEAR) begin
                    r_sweep     <= '0;
                    r_sweep_end <= SW'(clr_bytes[17:3]);
                end
            end else if (r_state == bcpu_pkg::ST_RUN) begin
                // issue the next byte read; the previous one returns this cycle
                if (o_rd_en) begin
                    r_k_iss <= r_k_iss + 4'd1;
                end
                r_pend   <= o_rd_en;
                r_pend_k <= r_k_iss;
                if (r_pend && r_act == bcpu_pkg::ACT_READ) begin
                    r_rwin[pend_bit +: 8] <= i_rd_data;
                end
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out_rdata <= rd_shift[bcpu_pkg::DATA_W-1:0];
                r_out_cnt   <= r_cnt;
                r_out_prev  <= r_prev;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.read_data         = r_out_rdata;
    assign o_rsp.done_count        = r_out_cnt;
    assign o_rsp.previous_position = r_out_prev;

endmodule

`default_nettype wire

// ===== sv/bit_cursor_pack_unpack_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bit_cursor_pack_unpack_top
// LSB-first bit stream reader/writer over a byte store with a bit cursor.
// ----------------------------------------------------------------------------
// One request at a time. After reset the store is zeroed by a pass over
// all STORE_BYTES bytes during which no request is taken. Read, write and
// zero pad go through the byte store one byte a cycle, writes and zero pads
// with a read-modify-write on the memory with registered read data: an access
// of n bits starting at bit offset o touches ceil((o+n)/8) bytes (up to nine).
// Seeks, unknown actions and accesses that clip to nothing touch no byte;
// clear sweeps ceil(size/8) bytes, one per cycle. In every case the result
// shows in the same cycle that the next request can be taken. The result sits
// in an output register, so the next request is taken while a result waits.
// The size used is buffer_bits (APB offset 0) capped at STORE_BYTES*8.
module bit_cursor_pack_unpack_top #(
    parameter int STORE_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bcpu_req_if.sink                      i_req,
    bcpu_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcpu_pkg::APB_AW-1:0]   paddr,
    input  logic [bcpu_pkg::APB_DW-1:0]   pwdata,
    output logic [bcpu_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    logic [15:0]   buffer_bits;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    bcpu_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_buffer_bits (buffer_bits)
    );

    bcpu_store #(
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bcpu_engine #(
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_buffer_bits (buffer_bits),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

endmodule

`default_nettype wire

// ===== sv/bcpu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcpu_checker
// Port-level checks of the bit cursor block, bound to the top level.
// ----------------------------------------------------------------------------
module bcpu_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic [bcpu_pkg::DATA_W-1:0]  i_rsp_read_data,
    input logic [bcpu_pkg::CNT_W-1:0]   i_rsp_done_count,
    input logic                         i_pready
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_done_count <= 7'd64)
        else $error("done_count above 64");

    // bits above the count must be zero
    a_read_zero_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_done_count < 7'd64 |->
        (i_rsp_read_data >> i_rsp_done_count) == '0)
        else $error("read_data has bits above done_count");

    // one request in flight: taking a request closes the door
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in work");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind bit_cursor_pack_unpack_top bcpu_checker u_bcpu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_read_data  (o_rsp.read_data),
    .i_rsp_done_count (o_rsp.done_count),
    .i_pready         (pready)
);

`default_nettype wire

// ===== verif/bcpu_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpu_result_checker
// Watches the request, result and APB channels of the bit cursor block. Keeps
// a shadow byte store, cursor and buffer size, works out the expected result
// of every accepted request and compares each accepted result with the
// oldest expectation.
// ----------------------------------------------------------------------------
module bcpu_result_checker
    import bcpu_pkg::*;
#(
    parameter int STORE_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bcpu_req_if               i_req,
    bcpu_rsp_if               i_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                o_fail_count,
    output int                o_outstanding
);

    localparam int unsigned STORE_BITS = STORE_BYTES * 8;

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  done_count;
        logic [POS_W-1:0]  previous_position;
    } bit_result_t;

    logic [7:0]   shadow_store [STORE_BYTES];
    int unsigned  bit_cursor;
    logic [15:0]  size_reg;
    bit_result_t  expected_results [$];
    int           mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    function automatic int unsigned usable_bits();
        return (size_reg > STORE_BITS) ? STORE_BITS : int'(size_reg);
    endfunction

    // limit to one access, then to the room left before the limit
    function automatic int unsigned clipped_count(int unsigned want, int unsigned limit);
        int unsigned room;
        if (want > MAX_ACCESS_BITS) begin
            want = MAX_ACCESS_BITS;
        end
        room = (bit_cursor < limit) ? limit - bit_cursor : 0;
        return (want > room) ? room : want;
    endfunction

    function automatic int unsigned merge_bits(logic [DATA_W-1:0] bits, int unsigned want);
        int unsigned n;
        int unsigned pos;
        int unsigned i;
        n = clipped_count(want, ((usable_bits() + 7) >> 3) << 3);
        for (i = 0; i < n; i++) begin
            pos = bit_cursor + i;
            if ((pos >> 3) < STORE_BYTES) begin
                shadow_store[pos >> 3][pos & BIT_IN_BYTE] = bits[i];
            end
        end
        bit_cursor += n;
        return n;
    endfunction

    function automatic int unsigned saturated_position(int pos);
        if (pos < 0) begin
            return 0;
        end
        if (pos > int'(usable_bits())) begin
            return usable_bits();
        end
        return pos;
    endfunction

    function automatic bit_result_t predict_result(logic [ACT_W-1:0] act, logic [CNT_W-1:0] cnt,
                                                   logic [DATA_W-1:0] wdata,
                                                   logic signed [OFS_W-1:0] ofs);
        bit_result_t res;
        int unsigned n;
        int unsigned pos;
        int unsigned i;
        int          move;
        res.read_data         = '0;
        res.previous_position = POS_W'(bit_cursor);
        move = int'(ofs);
        n    = 0;
        case (act)
            ACT_READ: begin
                n = clipped_count(cnt, usable_bits());
                for (i = 0; i < n; i++) begin
                    pos = bit_cursor + i;
                    if ((pos >> 3) < STORE_BYTES) begin
                        res.read_data[i] = shadow_store[pos >> 3][pos & BIT_IN_BYTE];
                    end
                end
                bit_cursor += n;
            end
            ACT_WRITE: begin
                n = merge_bits(wdata, cnt);
            end
            ACT_SEEK_ABS: begin
                bit_cursor = saturated_position(move);
            end
            ACT_SEEK_REL: begin
                bit_cursor = saturated_position(int'(bit_cursor) + move);
            end
            ACT_ZERO_PAD: begin
                if ((bit_cursor & BIT_IN_BYTE) != 0) begin
                    n = merge_bits('0, 8 - (bit_cursor & BIT_IN_BYTE));
                end
            end
            ACT_CLEAR: begin
                for (i = 0; i < ((usable_bits() + 7) >> 3); i++) begin
                    shadow_store[i] = '0;
                end
            end
            default: begin
            end
        endcase
        res.done_count = CNT_W'(n);
        return res;
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (want !== got) begin
            mismatch_total++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        bit_result_t want;
        if (!i_rst_n) begin
            foreach (shadow_store[b]) begin
                shadow_store[b] = '0;
            end
            bit_cursor = 0;
            size_reg   = BUFFER_BITS_RESET;
            expected_results.delete();
            o_outstanding <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_BUFFER_BITS) begin
                size_reg = pwdata[15:0];
            end
            if (i_req.valid && i_req.ready) begin
                expected_results.push_back(predict_result(i_req.action, i_req.bit_count,
                                                          i_req.write_data,
                                                          i_req.seek_offset));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: result with no request pending, expected none got %0h/%0h/%0h",
                             $time, i_rsp.read_data, i_rsp.done_count,
                             i_rsp.previous_position);
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, i_rsp.read_data);
                    check_field("done_count", DATA_W'(want.done_count),
                                DATA_W'(i_rsp.done_count));
                    check_field("previous_position", DATA_W'(want.previous_position),
                                DATA_W'(i_rsp.previous_position));
                end
            end
            o_outstanding <= expected_results.size();
        end
    end

endmodule

// ===== verif/bit_cursor_pack_unpack_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_cursor_pack_unpack_top_test
// Drives the bit cursor block with a directed opening and random phases at
// several buffer sizes, with bursty requests and a stalling result sink.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module bit_cursor_pack_unpack_top_test;
    import bcpu_pkg::*;

    localparam int STORE_BYTES     = 4096;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 16;

    localparam logic [ACT_W-1:0] ACT_RESERVED_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RESERVED_B = 3'd7;

    localparam int READY_ALWAYS  = 0;
    localparam int READY_RANDOM  = 1;
    localparam int READY_PATTERN = 2;
    localparam int READY_SPARSE  = 3;

    typedef struct {
        logic [ACT_W-1:0]        action;
        logic [CNT_W-1:0]        bit_count;
        logic [DATA_W-1:0]       write_data;
        logic signed [OFS_W-1:0] seek_offset;
    } bit_request_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                outstanding;
    logic              drain_ok;
    bit_request_t      pending_requests [$];

    bcpu_req_if req_ch ();
    bcpu_rsp_if rsp_ch ();

    bit_cursor_pack_unpack_top #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bcpu_result_checker #(
        .STORE_BYTES (STORE_BYTES)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result sink: repeatedly picks a stall behavior: always ready, random, or a rotating pattern, sparse or not
    initial begin
        int          stall_mode;
        logic [31:0] stall_word;
        rsp_ch.ready <= 1'b0;
        forever begin
            stall_mode = $urandom_range(READY_ALWAYS, READY_SPARSE);
            stall_word = $urandom;
            if (stall_mode == READY_SPARSE) begin
                stall_word = stall_word & $urandom & $urandom;
            end
            stall_word[0] = 1'b1;
            repeat (64) begin
                @(posedge i_clk);
                case (stall_mode)
                    READY_ALWAYS: rsp_ch.ready <= 1'b1;
                    READY_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        rsp_ch.ready <= stall_word[0];
                        stall_word = {stall_word[0], stall_word[31:1]};
                    end
                endcase
            end
        end
    end

    function automatic void add_request(logic [ACT_W-1:0] act, logic [CNT_W-1:0] cnt,
                                        logic [DATA_W-1:0] wdata,
                                        logic signed [OFS_W-1:0] ofs);
        bit_request_t r;
        r.action      = act;
        r.bit_count   = cnt;
        r.write_data  = wdata;
        r.seek_offset = ofs;
        pending_requests.push_back(r);
    endfunction

    // mostly reads and writes; relative seeks lean backward to revisit data
    function automatic bit_request_t random_request(int unsigned size);
        bit_request_t r;
        int unsigned  pick;
        pick          = $urandom_range(0, 999);
        r.write_data  = {$urandom, $urandom};
        r.seek_offset = OFS_W'($urandom);
        r.bit_count   = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(65, 127))
                                                    : CNT_W'($urandom_range(0, 64));
        if (pick < 350) begin
            r.action = ACT_READ;
        end else if (pick < 700) begin
            r.action = ACT_WRITE;
        end else if (pick < 820) begin
            r.action = ACT_SEEK_REL;
            if ($urandom_range(0, 4) != 0) begin
                r.seek_offset = OFS_W'($urandom_range(0, 300)) - OFS_W'(200);
            end
        end else if (pick < 880) begin
            r.action = ACT_SEEK_ABS;
            if ($urandom_range(0, 4) != 0) begin
                r.seek_offset = OFS_W'($urandom_range(0, size));
            end
        end else if (pick < 960) begin
            r.action = ACT_ZERO_PAD;
        end else if (pick < 985) begin
            r.action = ($urandom_range(0, 1) != 0) ? ACT_RESERVED_A : ACT_RESERVED_B;
        end else begin
            r.action = ACT_CLEAR;
        end
        return r;
    endfunction

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // send queued requests in bursts; valid stays high within a burst
    task automatic drive_requests();
        bit_request_t r;
        int           burst_left;
        int           gap;
        burst_left = $urandom_range(1, 24);
        while (pending_requests.size() != 0) begin
            r = pending_requests.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.action      <= r.action;
            req_ch.bit_count   <= r.bit_count;
            req_ch.write_data  <= r.write_data;
            req_ch.seek_offset <= r.seek_offset;
            do @(posedge i_clk); while (!req_ch.ready);
            burst_left--;
            if (pending_requests.size() == 0 || burst_left == 0) begin
                req_ch.valid <= 1'b0;
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 6);
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic wait_drain();
        int waited;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (outstanding != 0 && waited < DRAIN_LIMIT);
        if (outstanding != 0) begin
            drain_ok = 1'b0;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned phase_sizes [8];
        int unsigned usable;
        drain_ok            = 1'b1;
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= ACT_READ;
        req_ch.bit_count   <= '0;
        req_ch.write_data  <= '0;
        req_ch.seek_offset <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= REG_BUFFER_BITS;
        pwdata             <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // opening at the reset size: clipping, unaligned merges, padding,
        // seek saturation, cursor at the very end, unknown actions, clear
        add_request(ACT_READ,     7'd0,   {$urandom, $urandom}, 17'd0);
        add_request(ACT_WRITE,    7'd64,  '1,                   17'd0);
        add_request(ACT_SEEK_REL, 7'd0,   {$urandom, $urandom}, -17'sd64);
        add_request(ACT_READ,     7'd127, {$urandom, $urandom}, 17'd0);
        add_request(ACT_SEEK_ABS, 7'd0,   '0,                   17'd3);
        add_request(ACT_WRITE,    7'd13,  '0,                   17'd0);
        add_request(ACT_WRITE,    7'd5,   64'h15,               17'd0);
        add_request(ACT_ZERO_PAD, 7'd0,   '1,                   17'd0);
        add_request(ACT_ZERO_PAD, 7'd0,   '1,                   17'd0);
        add_request(ACT_SEEK_ABS, 7'd0,   '0,                   17'd0);
        add_request(ACT_READ,     7'd64,  '0,                   17'd0);
        add_request(ACT_SEEK_ABS, 7'd0,   '0,                   17'd5);
        add_request(ACT_WRITE,    7'd64,  64'hA5A5_5A5A_0F0F_F0F0, 17'd0);
        add_request(ACT_SEEK_REL, 7'd0,   '0,                   -17'sd64);
        add_request(ACT_READ,     7'd64,  '0,                   17'd0);
        add_request(ACT_SEEK_ABS, 7'd0,   '0,                   17'h1_0000);
        add_request(ACT_SEEK_ABS, 7'd0,   '0,                   17'h0_FFFF);
        add_request(ACT_READ,     7'd64,  '0,                   17'd0);
        add_request(ACT_WRITE,    7'd64,  '1,                   17'd0);
        add_request(ACT_SEEK_REL, 7'd0,   '0,                   -17'sd1);
        add_request(ACT_WRITE,    7'd64,  '1,                   17'd0);
        add_request(ACT_SEEK_REL, 7'd0,   '0,                   17'h0_FFFF);
        add_request(ACT_RESERVED_A, 7'd64, '1,                  17'h1_FFFF);
        add_request(ACT_RESERVED_B, 7'd64, '1,                  17'h1_FFFF);
        add_request(ACT_CLEAR,    7'd0,   '0,                   17'd0);
        add_request(ACT_SEEK_ABS, 7'd0,   '0,                   17'd0);
        add_request(ACT_READ,     7'd64,  '0,                   17'd0);
        drive_requests();
        wait_drain();

        phase_sizes = '{13, 0, 65535, 1, 32767, 100, 2, 32768};
        phase_sizes[6] = $urandom_range(2, 4000);
        foreach (phase_sizes[p]) begin
            apb_write(REG_BUFFER_BITS, APB_DW'(phase_sizes[p]));
            usable = (phase_sizes[p] > STORE_BYTES * 8) ? STORE_BYTES * 8 : phase_sizes[p];
            repeat (ITEMS_PER_PHASE) begin
                pending_requests.push_back(random_request(usable));
            end
            drive_requests();
            wait_drain();
        end

        if (drain_ok && fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/bcpu_pkg.sv
sv/bcpu_stream_if.sv
sv/bcpu_apb_regs.sv
sv/bcpu_store.sv
sv/bcpu_engine.sv
sv/bit_cursor_pack_unpack_top.sv
sv/bcpu_checker.sv
verif/bcpu_result_checker.sv
verif/bit_cursor_pack_unpack_top_test.sv
